@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the blob shape checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/tbsv_pkg.sv @@
// Package of the blob shape checker: widths, codes and parameter defaults.
// Used by tensor_blob_shape_validator_unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tbsv_pkg;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_TENSORS = 64;
  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_COUNT_BITS  = 40;

  // Fixed field widths.
  localparam int WORD_W       = 32;
  localparam int TENSOR_IN_W  = 6;
  localparam int SLOT_IN_W    = 3;
  localparam int TCOUNT_W     = 7;
  localparam int STATUS_W     = 4;
  localparam int ERR_TENSOR_W = 6;
  localparam int ERR_DIM_W    = 2;
  localparam int TRAIL_W      = 24;
  localparam int CFG_IDX_W    = 1;
  localparam int MUL_W        = 64;

  localparam logic [TRAIL_W-1:0] TRAIL_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

  // Request kinds.
  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_BLOB  = 1'b1;

  // Status codes reported at the end of a blob.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 4'd0,
    ST_TOO_SMALL     = 4'd1,
    ST_MAGIC         = 4'd2,
    ST_COUNT         = 4'd3,
    ST_CUT_NDIM      = 4'd4,
    ST_NDIM_MISMATCH = 4'd5,
    ST_CUT_DIM       = 4'd6,
    ST_DIM_MISMATCH  = 4'd7,
    ST_CUT_DATA      = 4'd8
  } status_t;

endpackage

`default_nettype wire

@@ rtl/tbsv_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Read-first on a same-address collision; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tbsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 320,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/tensor_blob_shape_validator_unit.sv @@
// Top level of the blob shape checker: input register, checker logic, result register.
// Depends on tbsv_pkg, tbsv_ram and assert_macros.svh.
//
//   Channel   Direction  Handshake              Payload
//   in_*      input      in_valid / in_ready    table write or one blob word
//   out_*     output     out_valid / out_ready  end-of-blob status and trailing count
//   cfg_*     input      cfg_wr_en              expected magic, expected tensor count
//
// One item per cycle unless a held result or the multiplier stalls; a matching
// dimension word holds back the next item while the saturating product runs through
// a two-step partial-product multiplier. The last word loads the result register.
// Reset is synchronous and clears all control state; the shape table is not cleared.
// A held result stalls the input only when the input register is also full.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tensor_blob_shape_validator_unit #(
  parameter int MAX_TENSORS = tbsv_pkg::DEF_MAX_TENSORS,
  parameter int MAX_DIMS    = tbsv_pkg::DEF_MAX_DIMS,
  parameter int COUNT_BITS  = tbsv_pkg::DEF_COUNT_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_req_type,
  input  wire logic [tbsv_pkg::TENSOR_IN_W-1:0]    in_table_tensor,
  input  wire logic [tbsv_pkg::SLOT_IN_W-1:0]      in_table_slot,
  input  wire logic [tbsv_pkg::WORD_W-1:0]         in_table_value,
  input  wire logic [tbsv_pkg::WORD_W-1:0]         in_blob_word,
  input  wire logic                                in_last_word,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [tbsv_pkg::STATUS_W-1:0]       out_status,
  output logic      [tbsv_pkg::ERR_TENSOR_W-1:0]   out_error_tensor,
  output logic      [tbsv_pkg::ERR_DIM_W-1:0]      out_error_dim,
  output logic      [tbsv_pkg::TRAIL_W-1:0]        out_trailing_words,
  output logic                                     out_trailing_flag,
  // Configuration port
  input  wire logic                                cfg_wr_en,
  input  wire logic [tbsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tbsv_pkg::WORD_W-1:0]         cfg_data
);

  import tbsv_pkg::*;

  localparam int STRIDE = MAX_DIMS + 1;
  localparam int DEPTH  = MAX_TENSORS * STRIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(MAX_DIMS + 1);

  typedef enum logic [2:0] {
    PH_MAGIC,
    PH_COUNT,
    PH_NDIM,
    PH_DIM,
    PH_DATA,
    PH_DONE
  } phase_t;

  // Configuration registers.
  logic [WORD_W-1:0]   exp_magic_r;
  logic [TCOUNT_W-1:0] exp_count_r;

  // Input register.
  logic                    in_valid_r;
  logic                    in_req_type_r;
  logic [TENSOR_IN_W-1:0]  in_table_tensor_r;
  logic [SLOT_IN_W-1:0]    in_table_slot_r;
  logic [WORD_W-1:0]       in_table_value_r;
  logic [WORD_W-1:0]       in_blob_word_r;
  logic                    in_last_word_r;

  // Checker state.
  phase_t                phase_r, phase_nxt;
  logic [TCOUNT_W-1:0]   tensor_r, tensor_nxt, tensor_inc;
  logic [ADDR_W-1:0]     base_r, base_nxt;
  logic [SLOT_W-1:0]     dim_r, dim_nxt, dim_inc;
  logic [SLOT_W-1:0]     dcount_r, dcount_nxt;
  logic [COUNT_BITS-1:0] prod_r, prod_nxt;
  status_t               err_code_r, err_code_nxt;
  logic [ERR_TENSOR_W-1:0] err_tensor_r, err_tensor_nxt;
  logic [ERR_DIM_W-1:0]  err_dim_r, err_dim_nxt;
  logic [TRAIL_W-1:0]    trail_r, trail_nxt;
  logic                  seen_r, seen_nxt;
  logic                  tdone;

  // Multiplier pipeline.
  logic                  mul_start;
  logic                  mul_busy_r;
  logic [MUL_W-1:0]      prod_ext;
  logic [MUL_W-1:0]      pp_lo_r, pp_hi_r;
  logic [MUL_W+WORD_W-1:0] pp_sum;
  logic                  pp_sat;
  logic [COUNT_BITS-1:0] prod_mul;

  // Shape table access.
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     slot_nxt;
  logic [WORD_W-1:0]     ram_rd_data;
  logic                  byp_hit_r;
  logic [WORD_W-1:0]     byp_data_r;
  logic                  oob_r;
  logic [WORD_W-1:0]     want;

  // Handshake and result.
  logic                  fire;
  logic                  is_blob;
  logic                  produce;
  logic [WORD_W-1:0]     word;
  logic [SLOT_W+1:0]     dim_r_ext, dim_nxt_ext;
  status_t               res_status;
  logic [ERR_TENSOR_W-1:0] res_tensor;
  logic [ERR_DIM_W-1:0]  res_dim;
  logic [TRAIL_W-1:0]    res_trail;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [ERR_TENSOR_W-1:0] out_error_tensor_r;
  logic [ERR_DIM_W-1:0]  out_error_dim_r;
  logic [TRAIL_W-1:0]    out_trailing_words_r;
  logic                  out_trailing_flag_r;

  // An item leaves the input register when the multiplier is free and the
  // result register can take a result.
  assign fire     = in_valid_r && !mul_busy_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;
  assign is_blob  = (in_req_type_r == REQ_BLOB);
  assign produce  = fire && is_blob && in_last_word_r;
  assign word     = in_blob_word_r;

  // Expected value for the current slot: a same-cycle write is bypassed, and a
  // tensor beyond the table reads as zero.
  assign want = oob_r ? '0 : (byp_hit_r ? byp_data_r : ram_rd_data);

  assign tensor_inc = tensor_r + 1'b1;
  assign dim_inc    = dim_r + 1'b1;

  // Word checking and state update.
  always_comb begin
    phase_nxt      = phase_r;
    tensor_nxt     = tensor_r;
    base_nxt       = base_r;
    dim_nxt        = dim_r;
    dcount_nxt     = dcount_r;
    prod_nxt       = prod_r;
    err_code_nxt   = err_code_r;
    err_tensor_nxt = err_tensor_r;
    err_dim_nxt    = err_dim_r;
    trail_nxt      = trail_r;
    seen_nxt       = seen_r;
    tdone          = 1'b0;
    mul_start      = 1'b0;
    if (fire && is_blob) begin
      seen_nxt = 1'b1;
      if (err_code_r == ST_OK) begin
        case (phase_r)
          PH_MAGIC: begin
            if (word != exp_magic_r) begin
              err_code_nxt   = ST_MAGIC;
              err_tensor_nxt = '0;
              err_dim_nxt    = '0;
            end else begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (word != WORD_W'(exp_count_r)) begin
              err_code_nxt   = ST_COUNT;
              err_tensor_nxt = '0;
              err_dim_nxt    = '0;
            end else begin
              tensor_nxt = '0;
              base_nxt   = '0;
              phase_nxt  = (exp_count_r == '0) ? PH_DONE : PH_NDIM;
            end
          end
          PH_NDIM: begin
            prod_nxt = COUNT_BITS'(1);
            dim_nxt  = '0;
            if (word != want) begin
              err_code_nxt   = ST_NDIM_MISMATCH;
              err_tensor_nxt = tensor_r[ERR_TENSOR_W-1:0];
              err_dim_nxt    = '0;
            end else if (word[WORD_W-1] || word == '0) begin
              // No dimensions, or a negative count: a single data word follows.
              dcount_nxt = '0;
              phase_nxt  = PH_DATA;
            end else if (word > WORD_W'(MAX_DIMS)) begin
              err_code_nxt   = ST_NDIM_MISMATCH;
              err_tensor_nxt = tensor_r[ERR_TENSOR_W-1:0];
              err_dim_nxt    = '0;
            end else begin
              dcount_nxt = word[SLOT_W-1:0];
              phase_nxt  = PH_DIM;
            end
          end
          PH_DIM: begin
            if (word != want) begin
              err_code_nxt   = ST_DIM_MISMATCH;
              err_tensor_nxt = tensor_r[ERR_TENSOR_W-1:0];
              err_dim_nxt    = dim_r_ext[ERR_DIM_W-1:0];
            end else begin
              mul_start = !in_last_word_r;
              dim_nxt   = dim_inc;
              if (dim_inc >= dcount_r) begin
                // A zero dimension anywhere leaves the tensor without data.
                if (prod_r == '0 || word == '0) begin
                  tdone = 1'b1;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end
          end
          PH_DATA: begin
            if (prod_r != '0) begin
              prod_nxt = prod_r - 1'b1;
            end
            if (prod_nxt == '0) begin
              tdone = 1'b1;
            end
          end
          PH_DONE: begin
            if (trail_r != TRAIL_MAX) begin
              trail_nxt = trail_r + 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_MAGIC;
          end
        endcase
      end
      // Move on to the next tensor or finish the tensor loop.
      if (tdone) begin
        tensor_nxt = tensor_inc;
        base_nxt   = (tensor_inc == '0) ? '0 : base_r + ADDR_W'(STRIDE);
        phase_nxt  = (tensor_inc >= exp_count_r) ? PH_DONE : PH_NDIM;
      end
    end
  end

  assign dim_r_ext   = (SLOT_W + 2)'(dim_r);
  assign dim_nxt_ext = (SLOT_W + 2)'(dim_nxt);

  // Result fields, taken from the state after the last word.
  always_comb begin
    res_status = ST_OK;
    res_tensor = '0;
    res_dim    = '0;
    res_trail  = '0;
    if (!seen_r) begin
      res_status = ST_TOO_SMALL;
    end else if (err_code_nxt != ST_OK) begin
      res_status = err_code_nxt;
      res_tensor = err_tensor_nxt;
      res_dim    = err_dim_nxt;
    end else begin
      case (phase_nxt)
        PH_NDIM: begin
          res_status = ST_CUT_NDIM;
          res_tensor = tensor_nxt[ERR_TENSOR_W-1:0];
        end
        PH_DIM: begin
          res_status = ST_CUT_DIM;
          res_tensor = tensor_nxt[ERR_TENSOR_W-1:0];
          res_dim    = dim_nxt_ext[ERR_DIM_W-1:0];
        end
        PH_DATA: begin
          res_status = ST_CUT_DATA;
          res_tensor = tensor_nxt[ERR_TENSOR_W-1:0];
        end
        PH_DONE: begin
          res_status = ST_OK;
          res_trail  = trail_nxt;
        end
        default: begin
          res_status = ST_TOO_SMALL;
        end
      endcase
    end
  end

  // Second multiplier step: combine the partial products and saturate.
  assign prod_ext = MUL_W'(prod_r);
  assign pp_sum   = {pp_hi_r, {WORD_W{1'b0}}} + (MUL_W + WORD_W)'(pp_lo_r);
  assign pp_sat   = |pp_sum[MUL_W+WORD_W-1:COUNT_BITS];
  assign prod_mul = pp_sat ? {COUNT_BITS{1'b1}} : pp_sum[COUNT_BITS-1:0];

  // Table write address and the read address for the next word.
  assign wr_en = fire && !is_blob
              && (32'(in_table_tensor_r) < 32'(MAX_TENSORS))
              && (32'(in_table_slot_r) <= 32'(MAX_DIMS));
  assign wr_addr = ADDR_W'(32'(in_table_tensor_r) * 32'(STRIDE) + 32'(in_table_slot_r));
  assign slot_nxt = (phase_nxt == PH_DIM) ? SLOT_W'(dim_nxt + 1'b1) : '0;
  assign rd_addr  = base_nxt + ADDR_W'(slot_nxt);

  tbsv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_shape_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_table_value_r),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // Control state, configuration and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_magic_r  <= '0;
      exp_count_r  <= '0;
      in_valid_r   <= 1'b0;
      phase_r      <= PH_MAGIC;
      tensor_r     <= '0;
      base_r       <= '0;
      dim_r        <= '0;
      dcount_r     <= '0;
      prod_r       <= COUNT_BITS'(1);
      err_code_r   <= ST_OK;
      err_tensor_r <= '0;
      err_dim_r    <= '0;
      trail_r      <= '0;
      seen_r       <= 1'b0;
      mul_busy_r   <= 1'b0;
      byp_hit_r    <= 1'b0;
      oob_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAGIC: exp_magic_r <= cfg_data;
          REG_COUNT: exp_count_r <= cfg_data[TCOUNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (produce) begin
        // End of blob: all stream state returns to its reset value.
        phase_r      <= PH_MAGIC;
        tensor_r     <= '0;
        base_r       <= '0;
        dim_r        <= '0;
        dcount_r     <= '0;
        prod_r       <= COUNT_BITS'(1);
        err_code_r   <= ST_OK;
        err_tensor_r <= '0;
        err_dim_r    <= '0;
        trail_r      <= '0;
        seen_r       <= 1'b0;
      end else begin
        phase_r      <= phase_nxt;
        tensor_r     <= tensor_nxt;
        base_r       <= base_nxt;
        dim_r        <= dim_nxt;
        dcount_r     <= dcount_nxt;
        prod_r       <= mul_busy_r ? prod_mul : prod_nxt;
        err_code_r   <= err_code_nxt;
        err_tensor_r <= err_tensor_nxt;
        err_dim_r    <= err_dim_nxt;
        trail_r      <= trail_nxt;
        seen_r       <= seen_nxt;
      end
      mul_busy_r <= mul_start;
      byp_hit_r  <= wr_en && (wr_addr == rd_addr);
      oob_r      <= (32'(tensor_nxt) >= 32'(MAX_TENSORS));
      if (produce) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_type_r     <= in_req_type;
      in_table_tensor_r <= in_table_tensor;
      in_table_slot_r   <= in_table_slot;
      in_table_value_r  <= in_table_value;
      in_blob_word_r    <= in_blob_word;
      in_last_word_r    <= in_last_word;
    end
    // First multiplier step: two 32 by 32 partial products.
    if (mul_start) begin
      pp_lo_r <= prod_ext[WORD_W-1:0] * word;
      pp_hi_r <= prod_ext[MUL_W-1:WORD_W] * word;
    end
    byp_data_r <= in_table_value_r;
    if (produce) begin
      out_status_r         <= res_status;
      out_error_tensor_r   <= res_tensor;
      out_error_dim_r      <= res_dim;
      out_trailing_words_r <= res_trail;
      out_trailing_flag_r  <= (res_trail != '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_error_tensor   = out_error_tensor_r;
  assign out_error_dim      = out_error_dim_r;
  assign out_trailing_words = out_trailing_words_r;
  assign out_trailing_flag  = out_trailing_flag_r;

  // A tensor in its data phase always has words left once its product is final.
  `ASSERT_IMPLIES(a_data_left, clk, rst_n,
    phase_r == PH_DATA && err_code_r == ST_OK && !mul_busy_r, prod_r != '0)
  // The dimension index stays below the dimension count while dimensions arrive.
  `ASSERT_IMPLIES(a_dim_range, clk, rst_n, phase_r == PH_DIM, dim_r < dcount_r)
  // A latched error holds until the end of the blob.
  `ASSERT_NEXT(a_err_latched, clk, rst_n,
    err_code_r != ST_OK && !produce, err_code_r == $past(err_code_r))

endmodule

`default_nettype wire
